>>> rtl/core/salsa_pkg.sv
`default_nettype none

package salsa_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int WORD_BITS   = 32;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [3:0]           widx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        ROT_NONE,
        ROT_7,
        ROT_9,
        ROT_13,
        ROT_18
    } rot_t;

    // State rearrangement applied after a step
    typedef enum logic [1:0] {
        SH_NONE,
        SH_FIVE,
        SH_ONE_T
    } shift_t;

    typedef struct packed {
        logic       load;
        logic       copy;
        logic       step;
        logic [1:0] step_idx;
        shift_t     shift;
        logic       emit;
        logic       err;
    } ctl_t;

    function automatic rot_t rot_for_step(input logic [1:0] s);
        rot_t r;
        case (s)
            2'd0:    r = ROT_7;
            2'd1:    r = ROT_9;
            2'd2:    r = ROT_13;
            default: r = ROT_18;
        endcase
        return r;
    endfunction

    function automatic word_t rotl(input word_t v, input rot_t r);
        word_t o;
        case (r)
            ROT_7:   o = {v[24:0], v[31:25]};
            ROT_9:   o = {v[22:0], v[31:23]};
            ROT_13:  o = {v[18:0], v[31:19]};
            ROT_18:  o = {v[13:0], v[31:14]};
            default: o = v;
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/salsa_qr_unit.sv
`default_nettype none

// One quarter-round step: z ^ rotl(x + y)
module salsa_qr_unit (
    input  salsa_pkg::word_t x,
    input  salsa_pkg::word_t y,
    input  salsa_pkg::word_t z,
    input  salsa_pkg::rot_t  rot,
    output salsa_pkg::word_t res
);
    import salsa_pkg::*;

    word_t sum;

    assign sum = x + y;
    assign res = z ^ rotl(sum, rot);

endmodule

`default_nettype wire

>>> rtl/core/salsa_dp.sv
`default_nettype none

module salsa_dp (
    input  logic             clk,
    input  salsa_pkg::word_t word_in,
    input  salsa_pkg::ctl_t  ctl,
    output salsa_pkg::word_t word_out
);
    import salsa_pkg::*;

    word_t in_reg   [BLOCK_WORDS];
    word_t in_next  [BLOCK_WORDS];
    word_t work_reg [BLOCK_WORDS];
    word_t work_next[BLOCK_WORDS];
    word_t upd      [BLOCK_WORDS];
    word_t out_reg;
    word_t out_next;

    widx_t xpos;
    widx_t ypos;
    widx_t tpos;
    word_t ux;
    word_t uy;
    word_t uz;
    rot_t  urot;
    word_t ures;

    // The active quarter always sits at positions 0, 4, 8, 12; the state is
    // rotated between quarters and transposed between half rounds.
    assign xpos = {ctl.step_idx, 2'b00};
    assign ypos = {ctl.step_idx - 2'd1, 2'b00};
    assign tpos = {ctl.step_idx + 2'd1, 2'b00};

    always_comb
    begin
        if (ctl.emit)
        begin
            ux   = work_reg[0];
            uy   = in_reg[0];
            uz   = '0;
            urot = ROT_NONE;
        end
        else
        begin
            ux   = work_reg[xpos];
            uy   = work_reg[ypos];
            uz   = work_reg[tpos];
            urot = rot_for_step(ctl.step_idx);
        end
    end

    salsa_qr_unit u_qr (
        .x   (ux),
        .y   (uy),
        .z   (uz),
        .rot (urot),
        .res (ures)
    );

    always_comb
    begin
        in_next  = in_reg;
        work_next = work_reg;
        upd      = work_reg;
        out_next = out_reg;

        if (ctl.load)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
                in_next[i] = in_reg[i + 1];
            in_next[BLOCK_WORDS - 1] = word_in;
        end

        if (ctl.copy)
            work_next = in_next;

        if (ctl.step)
        begin
            upd[tpos] = ures;
            case (ctl.shift)
                SH_FIVE:
                begin
                    for (int i = 0; i < BLOCK_WORDS; i++)
                        work_next[i] = upd[widx_t'(i + 5)];
                end
                SH_ONE_T:
                begin
                    // shift by one, then transpose the 4x4 state
                    for (int r = 0; r < 4; r++)
                        for (int c = 0; c < 4; c++)
                            work_next[4 * r + c] = upd[widx_t'(4 * c + r + 1)];
                end
                default:
                    work_next = upd;
            endcase
        end

        if (ctl.emit)
        begin
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                work_next[i] = work_reg[widx_t'(i + 1)];
                in_next[i]   = in_reg[widx_t'(i + 1)];
            end
            out_next = ures;
        end

        if (ctl.err)
            out_next = '0;
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        work_reg <= work_next;
        out_reg  <= out_next;
    end

    assign word_out = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/salsa_ctrl.sv
`default_nettype none

module salsa_ctrl #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            last_word,
    output logic            busy,
    output logic            strobe,
    output logic            last_out,
    output logic            error,
    output salsa_pkg::ctl_t ctl
);
    import salsa_pkg::*;

    localparam int RW = $clog2(DOUBLE_ROUNDS);

    state_t        state_reg,   state_next;
    logic [1:0]    step_reg,    step_next;
    logic [1:0]    quarter_reg, quarter_next;
    logic          half_reg,    half_next;
    logic [RW-1:0] round_reg,   round_next;
    logic [3:0]    count_reg,   count_next;
    logic          strobe_reg,  strobe_next;
    logic          last_reg,    last_next;
    logic          error_reg,   error_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            quarter_reg <= '0;
            half_reg    <= 1'b0;
            round_reg   <= '0;
            count_reg   <= '0;
            strobe_reg  <= 1'b0;
            last_reg    <= 1'b0;
            error_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            quarter_reg <= quarter_next;
            half_reg    <= half_next;
            round_reg   <= round_next;
            count_reg   <= count_next;
            strobe_reg  <= strobe_next;
            last_reg    <= last_next;
            error_reg   <= error_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        quarter_next = quarter_reg;
        half_next    = half_reg;
        round_next   = round_reg;
        count_next   = count_reg;
        strobe_next  = 1'b0;
        last_next    = 1'b0;
        error_next   = 1'b0;
        ctl          = '{default: '0, shift: SH_NONE};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    if (count_reg == 4'd15)
                    begin
                        count_next = '0;
                        if (last_word)
                        begin
                            ctl.copy     = 1'b1;
                            state_next   = ST_ROUND;
                            step_next    = '0;
                            quarter_next = '0;
                            half_next    = 1'b0;
                            round_next   = '0;
                        end
                        else
                        begin
                            ctl.err     = 1'b1;
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            error_next  = 1'b1;
                        end
                    end
                    else if (last_word)
                    begin
                        // early last flag
                        count_next  = '0;
                        ctl.err     = 1'b1;
                        strobe_next = 1'b1;
                        last_next   = 1'b1;
                        error_next  = 1'b1;
                    end
                    else
                        count_next = count_reg + 4'd1;
                end
            end

            ST_ROUND:
            begin
                ctl.step     = 1'b1;
                ctl.step_idx = step_reg;
                step_next    = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    quarter_next = quarter_reg + 2'd1;
                    if (quarter_reg == 2'd3)
                    begin
                        ctl.shift = SH_ONE_T;
                        half_next = ~half_reg;
                        if (half_reg)
                        begin
                            round_next = round_reg + RW'(1);
                            if (round_reg == RW'(DOUBLE_ROUNDS - 1))
                            begin
                                state_next = ST_EMIT;
                                count_next = '0;
                            end
                        end
                    end
                    else
                        ctl.shift = SH_FIVE;
                end
            end

            ST_EMIT:
            begin
                ctl.emit    = 1'b1;
                strobe_next = 1'b1;
                last_next   = (count_reg == 4'd15);
                count_next  = count_reg + 4'd1;
                if (count_reg == 4'd15)
                    state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy     = (state_reg != ST_IDLE);
    assign strobe   = strobe_reg;
    assign last_out = last_reg;
    assign error    = error_reg;

endmodule

`default_nettype wire

>>> rtl/core/salsa20_core_hash_top.sv
// Salsa20 core hash. Words of a 64-byte block are taken one per item while busy
// is low, word 0 first; the sixteenth must carry last_word. A block then runs
// 2*DOUBLE_ROUNDS half rounds as 32*DOUBLE_ROUNDS single add-rotate-xor steps
// through one shared unit, one step per cycle, and the sixteen result words follow
// on consecutive cycles, each marked by strobe for one cycle, last_out on the
// sixteenth. busy rises once the last word is taken, stays high through the rounds
// and the result words, and falls as the final result is shown. A misplaced or
// missing last flag gives one result with error and last_out set the cycle after
// the offending word; busy stays low.
// There is no back-pressure: results must be taken as they appear.
`default_nettype none

module salsa20_core_hash_top #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] word_in,
    input  logic        last_word,
    output logic        strobe,
    output logic [31:0] word_out,
    output logic        last_out,
    output logic        error
);
    import salsa_pkg::*;

    ctl_t ctl;

    salsa_ctrl #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_word (last_word),
        .busy      (busy),
        .strobe    (strobe),
        .last_out  (last_out),
        .error     (error),
        .ctl       (ctl)
    );

    salsa_dp u_dp (
        .clk      (clk),
        .word_in  (word_in),
        .ctl      (ctl),
        .word_out (word_out)
    );

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && error |-> last_out)
        else $error("error result without last_out");

    a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_out |-> busy && !error)
        else $error("intermediate result outside a block run");

    a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_out && !error |-> !busy)
        else $error("busy still high on final result");

    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start) && $past(last_word))
        else $error("run started without a last word accepted");

endmodule

`default_nettype wire

>>> tb/sv/salsa20_core_hash_top_tb.sv
`default_nettype none

module salsa20_core_hash_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import salsa_pkg::*;

    localparam int DR_COUNT   = 10;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 40;

    typedef enum int {
        BLK_GOOD,
        BLK_EARLY_LAST,
        BLK_NO_LAST
    } blk_shape_t;

    typedef struct packed {
        word_t word;
        logic  last;
        logic  err;
    } hash_res_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] word_in;
    logic        last_word;
    logic        strobe;
    logic [31:0] word_out;
    logic        last_out;
    logic        error;

    word_t     kept_words [BLOCK_WORDS];
    word_t     mix_words [BLOCK_WORDS];
    int        word_pos;
    hash_res_t pending_res[$];
    int        fail_count;
    int        quiet_cycles;
    int        words_sent;
    bit        gaps_on;

    salsa20_core_hash_top #(
        .DOUBLE_ROUNDS(DR_COUNT)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .word_in  (word_in),
        .last_word(last_word),
        .strobe   (strobe),
        .word_out (word_out),
        .last_out (last_out),
        .error    (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic word_t rotl32(input word_t v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter_mix(input int a, input int b, input int c, input int d);
        mix_words[b] ^= rotl32(mix_words[a] + mix_words[d], 7);
        mix_words[c] ^= rotl32(mix_words[b] + mix_words[a], 9);
        mix_words[d] ^= rotl32(mix_words[c] + mix_words[b], 13);
        mix_words[a] ^= rotl32(mix_words[d] + mix_words[c], 18);
    endfunction

    // Runs the hash over kept_words and queues the sixteen sums
    function automatic void queue_hash();
        hash_res_t r;
        for (int i = 0; i < BLOCK_WORDS; i++)
            mix_words[i] = kept_words[i];
        for (int k = 0; k < DR_COUNT; k++)
        begin
            quarter_mix(0, 4, 8, 12);
            quarter_mix(5, 9, 13, 1);
            quarter_mix(10, 14, 2, 6);
            quarter_mix(15, 3, 7, 11);
            quarter_mix(0, 1, 2, 3);
            quarter_mix(5, 6, 7, 4);
            quarter_mix(10, 11, 8, 9);
            quarter_mix(15, 12, 13, 14);
        end
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            r.word = mix_words[i] + kept_words[i];
            r.last = (i == BLOCK_WORDS - 1);
            r.err  = 1'b0;
            pending_res.push_back(r);
        end
    endfunction

    function automatic void queue_length_error();
        hash_res_t r;
        r.word = '0;
        r.last = 1'b1;
        r.err  = 1'b1;
        pending_res.push_back(r);
        word_pos = 0;
    endfunction

    function automatic void predict_word(input word_t w, input logic l);
        kept_words[word_pos] = w;
        if (word_pos < BLOCK_WORDS - 1)
        begin
            if (l)
                queue_length_error();
            else
                word_pos++;
        end
        else if (!l)
            queue_length_error();
        else
        begin
            queue_hash();
            word_pos = 0;
        end
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Holds start until the item is taken, then maybe leaves a gap
    task automatic send_word(input word_t w, input logic l);
        word_in   <= w;
        last_word <= l;
        start     <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_word(w, l);
        words_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_block(input blk_shape_t shape);
        int cut;
        cut = $urandom_range(0, BLOCK_WORDS - 2);
        case (shape)
            BLK_EARLY_LAST:
            begin
                for (int i = 0; i < cut; i++)
                    send_word(rand_word(), 1'b0);
                send_word(rand_word(), 1'b1);
            end
            BLK_NO_LAST:
                for (int i = 0; i < BLOCK_WORDS; i++)
                    send_word(rand_word(), 1'b0);
            default:
                for (int i = 0; i < BLOCK_WORDS; i++)
                    send_word(rand_word(), i == BLOCK_WORDS - 1);
        endcase
    endtask

    task automatic test_extreme_words();
        for (int i = 0; i < BLOCK_WORDS; i++)
            send_word(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, i == BLOCK_WORDS - 1);
    endtask

    task automatic test_early_last();
        // flag on the very first word, then on the fourth
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h8000_0001, 1'b0);
        send_word(32'h7FFF_FFFE, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_random_blocks();
        int pick;
        while (words_sent < 175)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_block(BLK_GOOD);
            else if (pick < 9)
                send_block(BLK_EARLY_LAST);
            else
                send_block(BLK_NO_LAST);
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        send_block(BLK_GOOD);
        send_block(BLK_NO_LAST);
        send_block(BLK_GOOD);
    endtask

    always @(posedge clk)
    begin
        hash_res_t exp_r;
        if (rst_n && strobe)
        begin
            if (pending_res.size() == 0)
            begin
                $error("result with nothing expected: word_out %h last_out %b error %b",
                       word_out, last_out, error);
                fail_count++;
            end
            else
            begin
                exp_r = pending_res.pop_front();
                if (word_out !== exp_r.word)
                begin
                    $error("word_out: expected %h, actual %h", exp_r.word, word_out);
                    fail_count++;
                end
                if (last_out !== exp_r.last)
                begin
                    $error("last_out: expected %b, actual %b", exp_r.last, last_out);
                    fail_count++;
                end
                if (error !== exp_r.err)
                begin
                    $error("error: expected %b, actual %b", exp_r.err, error);
                    fail_count++;
                end
            end
        end
    end

    // Nothing taken or shown for too long means the block has hung
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_MAX)
        begin
            $display("salsa20_core_hash_top_tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        word_in      = '0;
        last_word    = 1'b0;
        word_pos     = 0;
        words_sent   = 0;
        gaps_on      = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_words();
        test_early_last();
        test_random_blocks();
        test_back_to_back();

        start <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("salsa20_core_hash_top_tb: done, clean");
        else
            $display("salsa20_core_hash_top_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/salsa_pkg.sv
rtl/core/salsa_qr_unit.sv
rtl/core/salsa_dp.sv
rtl/core/salsa_ctrl.sv
rtl/core/salsa20_core_hash_top.sv
tb/sv/salsa20_core_hash_top_tb.sv
